// ===== hw/rtl/psrt_pkg.sv =====
// ----------------------------------------------------------------------------
// psrt_pkg
// shared types and codes for the pair set route table
// ----------------------------------------------------------------------------
package psrt_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int SRC_W   = 32;
  localparam int LINK_W  = 32;
  localparam int TOTAL_W = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [SRC_W-1:0]  source;
    logic [LINK_W-1:0] link;
  } entry_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/pair_set_route_table.sv =====
// ----------------------------------------------------------------------------
// pair_set_route_table
// bounded set of unique (source, link) pairs with add, remove and clear
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | tuser: opcode, tdata: source_id, link_id
//  m_      | out | m_tvalid / m_tready | tuser: status, tdata: entry_total
//
//  add and remove read every slot, one table read per cycle through the single
//  read port, make the last compare in the drain state and write back in the done
//  state as the result is loaded. clear writes one slot per cycle, the unused
//  opcode goes straight to the done state. s_tready rises the cycle after the
//  result is loaded. after reset a sweep clears every slot before s_tready
//  rises. a result waits in the output register while a new item is taken; the
//  write-back stalls only if that register is still full.
// ----------------------------------------------------------------------------
module pair_set_route_table #(
  parameter int CAPACITY = psrt_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] source_id, [63:32] link_id
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] entry_total, [7] zero
  output logic [2:0]  m_tuser    // [2:0] status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  psrt_pkg::state_t state, state_next;

  logic [AW-1:0]                  addr;
  logic                           last;
  logic                           accept;

  psrt_pkg::op_t                  op_q;
  logic [psrt_pkg::SRC_W-1:0]     src_q;
  logic [psrt_pkg::LINK_W-1:0]    lnk_q;

  psrt_pkg::entry_t               mem [CAPACITY];
  psrt_pkg::entry_t               rd_data;
  logic                           cmp_vld;
  logic [AW-1:0]                  cmp_idx;

  logic                           hit;
  logic [AW-1:0]                  hit_idx;
  logic                           free_hit;
  logic [AW-1:0]                  free_idx;

  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  psrt_pkg::status_t              status_next;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  psrt_pkg::entry_t               mem_wdata;
  logic                           done_fire;

  logic                           out_valid;
  psrt_pkg::status_t              out_status;
  logic [psrt_pkg::TOTAL_W-1:0]   out_total;

  assign last   = (addr == AW'(CAPACITY - 1));
  assign accept = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psrt_pkg::S_INIT: begin
        if (last) state_next = psrt_pkg::S_IDLE;
      end
      psrt_pkg::S_IDLE: begin
        if (accept) begin
          case (psrt_pkg::op_t'(s_tuser))
            psrt_pkg::OP_ADD, psrt_pkg::OP_REMOVE: state_next = psrt_pkg::S_SCAN;
            psrt_pkg::OP_CLEAR:                    state_next = psrt_pkg::S_CLEAR;
            default:                               state_next = psrt_pkg::S_DONE;
          endcase
        end
      end
      psrt_pkg::S_SCAN: begin
        if (last) state_next = psrt_pkg::S_DRAIN;
      end
      psrt_pkg::S_DRAIN: state_next = psrt_pkg::S_DONE;
      psrt_pkg::S_CLEAR: begin
        if (last) state_next = psrt_pkg::S_DONE;
      end
      psrt_pkg::S_DONE: begin
        if (done_fire) state_next = psrt_pkg::S_IDLE;
      end
      default: state_next = psrt_pkg::S_INIT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready    = (state == psrt_pkg::S_IDLE);
    done_fire   = (state == psrt_pkg::S_DONE) && (!out_valid || m_tready);
    mem_we      = 1'b0;
    mem_waddr   = addr;
    mem_wdata   = '{valid: 1'b0, source: src_q, link: lnk_q};
    status_next = psrt_pkg::ST_NOTFOUND;
    count_next  = count;
    case (state)
      psrt_pkg::S_INIT, psrt_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      psrt_pkg::S_DONE: begin
        case (op_q)
          psrt_pkg::OP_ADD: begin
            if (hit) begin
              status_next = psrt_pkg::ST_DUPLICATE;
            end else if (free_hit) begin
              status_next     = psrt_pkg::ST_ADDED;
              mem_we          = 1'b1;
              mem_waddr       = free_idx;
              mem_wdata.valid = 1'b1;
              count_next      = CW'(count + 1'b1);
            end else begin
              status_next = psrt_pkg::ST_FULL;
            end
          end
          psrt_pkg::OP_REMOVE: begin
            if (hit) begin
              status_next = psrt_pkg::ST_REMOVED;
              mem_we      = 1'b1;
              mem_waddr   = hit_idx;
              count_next  = CW'(count - 1'b1);
            end
          end
          psrt_pkg::OP_CLEAR: begin
            status_next = psrt_pkg::ST_CLEARED;
            count_next  = '0;
          end
          default: status_next = psrt_pkg::ST_NOTFOUND;
        endcase
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psrt_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // slot address for the reset sweep, the scan and the clear
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (state == psrt_pkg::S_INIT || state == psrt_pkg::S_SCAN ||
                 state == psrt_pkg::S_CLEAR) begin
      addr <= last ? '0 : AW'(addr + 1'b1);
    end else if (accept) begin
      addr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= psrt_pkg::op_t'(s_tuser);
      src_q <= s_tdata[31:0];
      lnk_q <= s_tdata[63:32];
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[addr];
    cmp_idx <= addr;
  end

  // shared compare on the slot read last cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld  <= 1'b0;
      hit      <= 1'b0;
      free_hit <= 1'b0;
    end else begin
      cmp_vld <= (state == psrt_pkg::S_SCAN);
      if (accept) begin
        hit      <= 1'b0;
        free_hit <= 1'b0;
      end else if (cmp_vld) begin
        if (rd_data.valid && rd_data.source == src_q && rd_data.link == lnk_q &&
            !hit) begin
          hit <= 1'b1;
        end
        if (!rd_data.valid && !free_hit) begin
          free_hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld && !hit && rd_data.valid && rd_data.source == src_q &&
        rd_data.link == lnk_q) begin
      hit_idx <= cmp_idx;
    end
    if (cmp_vld && !free_hit && !rd_data.valid) begin
      free_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (done_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_status <= status_next;
      out_total  <= psrt_pkg::TOTAL_W'(count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_total};
  assign m_tuser  = out_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("pair count above capacity");

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    done_fire && status_next == psrt_pkg::ST_ADDED |=> count == CW'($past(count) + 1'b1))
    else $error("add did not raise the pair count");

  a_clear_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == psrt_pkg::ST_CLEARED |-> out_total == '0)
    else $error("clear result with nonzero total");

  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    done_fire && status_next == psrt_pkg::ST_FULL |-> count == CW'(CAPACITY))
    else $error("full reported with a free slot");

endmodule

// ===== sim/psrt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psrt_checker
// watches both streams of the pair set route table, keeps its own copy of the
// table and compares every result against the outcome it predicts
// ----------------------------------------------------------------------------
module psrt_checker #(
  parameter int CAPACITY = psrt_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] source_id, [63:32] link_id
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [6:0] entry_total, [7] zero
  input  logic [2:0]  m_tuser,   // [2:0] status
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    psrt_pkg::status_t            status;
    logic [psrt_pkg::TOTAL_W-1:0] total;
  } outcome_t;

  logic                        held      [CAPACITY];
  logic [psrt_pkg::SRC_W-1:0]  held_src  [CAPACITY];
  logic [psrt_pkg::LINK_W-1:0] held_link [CAPACITY];
  int unsigned                 pair_total;
  outcome_t                    outcome_q [$];

  // applies one request to the shadow table and returns what the block must report
  function automatic outcome_t apply_table_op(psrt_pkg::op_t op,
                                              logic [psrt_pkg::SRC_W-1:0] src,
                                              logic [psrt_pkg::LINK_W-1:0] lnk);
    int       hit;
    int       vacant;
    outcome_t res;
    hit    = -1;
    vacant = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (held[i] && held_src[i] == src && held_link[i] == lnk && hit < 0) hit = i;
      if (!held[i] && vacant < 0) vacant = i;
    end
    case (op)
      psrt_pkg::OP_ADD: begin
        // a match wins over a full table
        if (hit >= 0) begin
          res.status = psrt_pkg::ST_DUPLICATE;
        end else if (vacant >= 0) begin
          held[vacant]      = 1'b1;
          held_src[vacant]  = src;
          held_link[vacant] = lnk;
          pair_total++;
          res.status = psrt_pkg::ST_ADDED;
        end else begin
          res.status = psrt_pkg::ST_FULL;
        end
      end
      psrt_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          held[hit] = 1'b0;
          if (pair_total > 0) pair_total--;
          res.status = psrt_pkg::ST_REMOVED;
        end else begin
          res.status = psrt_pkg::ST_NOTFOUND;
        end
      end
      psrt_pkg::OP_CLEAR: begin
        foreach (held[i]) held[i] = 1'b0;
        pair_total = 0;
        res.status = psrt_pkg::ST_CLEARED;
      end
      default: begin
        res.status = psrt_pkg::ST_NOTFOUND;
      end
    endcase
    res.total = psrt_pkg::TOTAL_W'(pair_total);
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      outcome_q.delete();
      foreach (held[i]) held[i] = 1'b0;
      pair_total = 0;
    end else begin
      // results leave before the item of this edge is queued
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          $error("unexpected item: status %0d, entry_total %0d", m_tuser,
                 m_tdata[psrt_pkg::TOTAL_W-1:0]);
        end else begin
          want = outcome_q.pop_front();
          if (m_tuser !== want.status) begin
            mismatches++;
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
          end
          if (m_tdata[psrt_pkg::TOTAL_W-1:0] !== want.total) begin
            mismatches++;
            $error("entry_total: expected %0d, actual %0d", want.total,
                   m_tdata[psrt_pkg::TOTAL_W-1:0]);
          end
          if (m_tdata[7:psrt_pkg::TOTAL_W] !== '0) begin
            mismatches++;
            $error("tdata pad: expected 0, actual %0d", m_tdata[7:psrt_pkg::TOTAL_W]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(apply_table_op(psrt_pkg::op_t'(s_tuser),
                                           s_tdata[psrt_pkg::SRC_W-1:0],
                                           s_tdata[63:psrt_pkg::SRC_W]));
      end
    end
    outstanding = outcome_q.size();
  end

endmodule

// ===== sim/tb_pair_set_route_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pair_set_route_table
// drives add, remove, clear and unused-opcode requests with random gaps and back pressure;
// the checker instance predicts and compares every result
// ----------------------------------------------------------------------------
module tb_pair_set_route_table;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int BLOCKS       = 10;
  localparam int BLOCK_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 600;
  localparam int SETTLE       = 80;
  localparam int POOL_MAX     = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    logic [psrt_pkg::SRC_W-1:0]  src;
    logic [psrt_pkg::LINK_W-1:0] lnk;
  } pair_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;    // [31:0] source_id, [63:32] link_id
  logic [1:0]  s_tuser  = '0;    // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [6:0] entry_total, [7] zero
  logic [2:0]  m_tuser;          // [2:0] status

  int    mismatches;
  int    outstanding;
  int    cycles  = 0;
  bit    no_idle = 1'b0;
  bit    rx_hold = 1'b0;
  pair_t pool [$];

  pair_set_route_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  psrt_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_item(psrt_pkg::op_t op, logic [psrt_pkg::SRC_W-1:0] src,
                           logic [psrt_pkg::LINK_W-1:0] lnk);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {lnk, src};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // called at the accepting edge; the last item must not be offered again
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // random traffic often reuses stored pairs so that hits are common
  task automatic pick_item(input bit filling, output psrt_pkg::op_t op,
                           output logic [psrt_pkg::SRC_W-1:0] src,
                           output logic [psrt_pkg::LINK_W-1:0] lnk);
    int    roll;
    int    k;
    pair_t p;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      src = $urandom_range(0, 3);
      lnk = $urandom_range(0, 3);
    end else begin
      src = $urandom;
      lnk = $urandom;
    end
    if (pool.size() > 0) begin
      k = $urandom_range(0, pool.size() - 1);
      p = pool[k];
    end else begin
      k     = -1;
      p.src = src;
      p.lnk = lnk;
    end
    if (filling) begin
      if (roll < 55) begin
        op = psrt_pkg::OP_ADD;
      end else if (roll < 70) begin
        op = psrt_pkg::OP_ADD;
        src = p.src;
        lnk = p.lnk;
      end else if (roll < 78) begin
        op = psrt_pkg::OP_ADD;
        src = p.src;
        lnk = p.lnk ^ (32'd1 << $urandom_range(0, 31));
      end else if (roll < 88) begin
        op = psrt_pkg::OP_REMOVE;
        src = p.src;
        lnk = p.lnk;
        if (k >= 0) pool.delete(k);
      end else if (roll < 96) begin
        op = psrt_pkg::OP_REMOVE;
      end else begin
        op = psrt_pkg::OP_UNUSED;
      end
    end else begin
      if (roll < 18) begin
        op = psrt_pkg::OP_ADD;
      end else if (roll < 28) begin
        op = psrt_pkg::OP_ADD;
        src = p.src;
        lnk = p.lnk;
      end else if (roll < 70) begin
        op = psrt_pkg::OP_REMOVE;
        src = p.src;
        lnk = p.lnk;
        if (k >= 0) pool.delete(k);
      end else if (roll < 80) begin
        // same source, one link bit off
        op = psrt_pkg::OP_REMOVE;
        src = p.src;
        lnk = p.lnk ^ (32'd1 << $urandom_range(0, 31));
      end else if (roll < 90) begin
        op = psrt_pkg::OP_REMOVE;
      end else if (roll < 94) begin
        op = psrt_pkg::OP_ADD;
        src = p.src ^ (32'd1 << $urandom_range(0, 31));
        lnk = p.lnk;
      end else if (roll < 97) begin
        op = psrt_pkg::OP_UNUSED;
      end else begin
        op = psrt_pkg::OP_CLEAR;
        pool.delete();
      end
    end
    if (op == psrt_pkg::OP_ADD) begin
      pool.push_back('{src, lnk});
      if (pool.size() > POOL_MAX) void'(pool.pop_front());
    end
  endtask

  // receiver: random stall per item, one long hold when asked
  initial begin
    int stall;
    do @(negedge clk); while (rst);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (rx_hold) begin
        stall   = HOLD_CYCLES;
        rx_hold = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      @(posedge clk);
    end
  end

  initial begin
    psrt_pkg::op_t               op;
    logic [psrt_pkg::SRC_W-1:0]  src;
    logic [psrt_pkg::LINK_W-1:0] lnk;
    do @(negedge clk); while (rst);
    @(posedge clk);

    send_item(psrt_pkg::OP_ADD,    32'h0000_0000, 32'h0000_0000);
    send_item(psrt_pkg::OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(psrt_pkg::OP_ADD,    32'h0000_0000, 32'h0000_0000);
    send_item(psrt_pkg::OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
    send_item(psrt_pkg::OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000);
    send_item(psrt_pkg::OP_REMOVE, 32'h1234_5678, 32'h0000_0000);
    send_item(psrt_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_item(psrt_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_item(psrt_pkg::OP_ADD,    32'h0000_0000, 32'h0000_0000);
    send_item(psrt_pkg::OP_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_item(psrt_pkg::OP_ADD,    32'hAAAA_AAAA, 32'h5555_5555);
    send_item(psrt_pkg::OP_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(psrt_pkg::OP_CLEAR,  32'h0000_0000, 32'h0000_0000);
    send_item(psrt_pkg::OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(psrt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(psrt_pkg::OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
    send_item(psrt_pkg::OP_ADD,    32'h8000_0000, 32'h0000_0001);
    send_item(psrt_pkg::OP_REMOVE, 32'h8000_0000, 32'h0000_0001);

    // even blocks fill the table past full, odd blocks drain it
    for (int b = 0; b < BLOCKS; b++) begin
      if (b == 3 || b == 7) wait_drained();
      if (b == 2) rx_hold = 1'b1;
      no_idle = (b % 5 == 4);
      for (int j = 0; j < BLOCK_ITEMS; j++) begin
        pick_item(b % 2 == 0, op, src, lnk);
        send_item(op, src, lnk);
      end
    end
    s_tvalid <= 1'b0;
    no_idle  = 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
